>>> rtl/cpc_pkg.sv
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types and constants of the clipped pixel compositor.
// ----------------------------------------------------------------------------
package cpc_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int ADDR_BITS_DEF  = 30;
  localparam int QUEUE_DEPTH    = 2;

  localparam int CLIP_BITS      = 15;
  localparam int STRIDE_BITS    = 14;
  localparam int BASE_BITS      = 30;
  localparam int CFG_DATA_BITS  = 30;
  localparam int CFG_INDEX_BITS = 3;

  localparam int CHAN_BITS      = 8;
  localparam int RGB_BITS       = 24;
  localparam int COLOR_BITS     = 32;

  localparam logic [CHAN_BITS-1:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [CHAN_BITS-1:0] ALPHA_CLEAR  = 8'd0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_CLIP_LEFT    = 3'd0,
    REG_CLIP_TOP     = 3'd1,
    REG_CLIP_RIGHT   = 3'd2,
    REG_CLIP_BOTTOM  = 3'd3,
    REG_ROW_STRIDE   = 3'd4,
    REG_BASE_ADDRESS = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    OP_PLOT  = 1'b0,
    OP_BLEND = 1'b1
  } op_t;

  // What the back end does with a pixel
  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,
    KIND_COPY = 2'd1,
    KIND_MIX  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CLIP_BITS-1:0]   clip_left;
    logic [CLIP_BITS-1:0]   clip_top;
    logic [CLIP_BITS-1:0]   clip_right;
    logic [CLIP_BITS-1:0]   clip_bottom;
    logic [STRIDE_BITS-1:0] row_stride;
    logic [BASE_BITS-1:0]   base_address;
  } cfg_t;

  typedef struct packed {
    kind_t                 kind;
    logic [CHAN_BITS-1:0]  alpha;
    logic [RGB_BITS-1:0]   src;
    logic [RGB_BITS-1:0]   dst;
  } pix_item_t;

endpackage

>>> rtl/cpc_front.sv
// ----------------------------------------------------------------------------
// cpc_front
// Configuration registers, clip test, pixel classification and the
// row offset product y * stride.
// ----------------------------------------------------------------------------
module cpc_front #(
  parameter int COORD_BITS = cpc_pkg::COORD_BITS_DEF,
  parameter int ADDR_BITS  = cpc_pkg::ADDR_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic [cpc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [cpc_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  output cpc_pkg::cfg_t                         cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  operation,
  input  logic signed [COORD_BITS-1:0]          x_pos,
  input  logic signed [COORD_BITS-1:0]          y_pos,
  input  logic [cpc_pkg::COLOR_BITS-1:0]        source_color,
  input  logic [cpc_pkg::RGB_BITS-1:0]          dest_pixel,
  output logic                                  f_valid,
  input  logic                                  f_ready,
  output cpc_pkg::pix_item_t                    f_item,
  output logic [ADDR_BITS-1:0]                  f_row_offs,
  output logic [ADDR_BITS-1:0]                  f_col_offs
);

  localparam int CMP_W  = (COORD_BITS > cpc_pkg::CLIP_BITS ? COORD_BITS : cpc_pkg::CLIP_BITS) + 1;
  localparam int PROD_W = COORD_BITS + cpc_pkg::STRIDE_BITS + 1;
  localparam int EXT_W  = PROD_W > ADDR_BITS ? PROD_W : ADDR_BITS;

  logic signed [CMP_W-1:0]  x_cmp, y_cmp;
  logic signed [CMP_W-1:0]  cl, ct, cr, cb;
  logic                     in_clip;
  logic [cpc_pkg::CHAN_BITS-1:0] alpha;
  cpc_pkg::kind_t           kind;
  logic signed [PROD_W-1:0] prod;
  logic signed [EXT_W-1:0]  prod_ext;
  logic signed [EXT_W-1:0]  x_ext;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.clip_left    <= '0;
      cfg.clip_top     <= '0;
      cfg.clip_right   <= '0;
      cfg.clip_bottom  <= '0;
      cfg.row_stride   <= cpc_pkg::STRIDE_BITS'(1);
      cfg.base_address <= '0;
    end else if (cfg_valid) begin
      case (cpc_pkg::cfg_reg_t'(cfg_index))
        cpc_pkg::REG_CLIP_LEFT:    cfg.clip_left    <= cfg_data[cpc_pkg::CLIP_BITS-1:0];
        cpc_pkg::REG_CLIP_TOP:     cfg.clip_top     <= cfg_data[cpc_pkg::CLIP_BITS-1:0];
        cpc_pkg::REG_CLIP_RIGHT:   cfg.clip_right   <= cfg_data[cpc_pkg::CLIP_BITS-1:0];
        cpc_pkg::REG_CLIP_BOTTOM:  cfg.clip_bottom  <= cfg_data[cpc_pkg::CLIP_BITS-1:0];
        cpc_pkg::REG_ROW_STRIDE:   cfg.row_stride   <= cfg_data[cpc_pkg::STRIDE_BITS-1:0];
        cpc_pkg::REG_BASE_ADDRESS: cfg.base_address <= cfg_data[cpc_pkg::BASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clip test in a common signed width
  assign x_cmp   = CMP_W'(x_pos);
  assign y_cmp   = CMP_W'(y_pos);
  assign cl      = $signed(CMP_W'(cfg.clip_left));
  assign ct      = $signed(CMP_W'(cfg.clip_top));
  assign cr      = $signed(CMP_W'(cfg.clip_right));
  assign cb      = $signed(CMP_W'(cfg.clip_bottom));
  assign in_clip = (x_cmp >= cl) && (x_cmp < cr) && (y_cmp >= ct) && (y_cmp < cb);

  assign alpha = source_color[cpc_pkg::COLOR_BITS-1 -: cpc_pkg::CHAN_BITS];

  always_comb begin
    if (!in_clip) begin
      kind = cpc_pkg::KIND_SKIP;
    end else if (cpc_pkg::op_t'(operation) == cpc_pkg::OP_PLOT ||
                 alpha == cpc_pkg::ALPHA_OPAQUE) begin
      kind = cpc_pkg::KIND_COPY;
    end else if (alpha == cpc_pkg::ALPHA_CLEAR) begin
      kind = cpc_pkg::KIND_SKIP;
    end else begin
      kind = cpc_pkg::KIND_MIX;
    end
  end

  assign prod     = PROD_W'(y_pos) * PROD_W'($signed({1'b0, cfg.row_stride}));
  assign prod_ext = EXT_W'(prod);
  assign x_ext    = EXT_W'(x_pos);

  assign in_ready = !f_valid || f_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item.kind  <= kind;
      f_item.alpha <= alpha;
      f_item.src   <= source_color[cpc_pkg::RGB_BITS-1:0];
      f_item.dst   <= dest_pixel;
      f_row_offs   <= prod_ext[ADDR_BITS-1:0];
      f_col_offs   <= x_ext[ADDR_BITS-1:0];
    end
  end

endmodule

>>> rtl/cpc_queue.sv
// ----------------------------------------------------------------------------
// cpc_queue
// Small FIFO between the front and the back end.
// ----------------------------------------------------------------------------
module cpc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cpc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/cpc_back.sv
// ----------------------------------------------------------------------------
// cpc_back
// Blend arithmetic and address sum: a multiply stage, then the output
// register with the divide-by-255 correction and pixel select.
// ----------------------------------------------------------------------------
module cpc_back #(
  parameter int ADDR_BITS = cpc_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [cpc_pkg::BASE_BITS-1:0]     base_address,
  input  logic                              b_valid,
  output logic                              b_ready,
  input  cpc_pkg::pix_item_t                b_item,
  input  logic [ADDR_BITS-1:0]              b_row_offs,
  input  logic [ADDR_BITS-1:0]              b_col_offs,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              write_enable,
  output logic [cpc_pkg::RGB_BITS-1:0]      new_pixel,
  output logic [ADDR_BITS-1:0]              pixel_address
);

  localparam int CB    = cpc_pkg::CHAN_BITS;
  localparam int NCH   = cpc_pkg::RGB_BITS / CB;
  localparam int PW    = 2 * CB;
  localparam int EXT_B = cpc_pkg::BASE_BITS > ADDR_BITS ? cpc_pkg::BASE_BITS : ADDR_BITS;

  // floor(n / 255) for n below 255 * 256
  function automatic logic [CB-1:0] div255(input logic [PW:0] n);
    logic [PW:0] t;
    t = n + (n >> CB) + (PW+1)'(1);
    return t[PW-1:CB];
  endfunction

  logic               s1_valid;
  cpc_pkg::kind_t     s1_kind;
  logic [cpc_pkg::RGB_BITS-1:0] s1_src, s1_dst;
  logic [PW-1:0]      s1_ms [NCH];
  logic [PW-1:0]      s1_md [NCH];
  logic [ADDR_BITS-1:0] s1_addr;
  logic               s1_ready, o_free;
  logic [EXT_B-1:0]   base_ext;
  logic [CB-1:0]      inv_alpha;
  logic [PW-1:0]      ms_next [NCH];
  logic [PW-1:0]      md_next [NCH];
  logic [cpc_pkg::RGB_BITS-1:0] mix_pix;

  assign o_free    = !out_valid || out_ready;
  assign s1_ready  = !s1_valid || o_free;
  assign b_ready   = s1_ready;
  assign base_ext  = EXT_B'(base_address);
  assign inv_alpha = cpc_pkg::ALPHA_OPAQUE - b_item.alpha;

  for (genvar c = 0; c < NCH; c++) begin : g_chan
    assign ms_next[c] = PW'(b_item.src[c*CB +: CB]) * PW'(b_item.alpha);
    assign md_next[c] = PW'(b_item.dst[c*CB +: CB]) * PW'(inv_alpha);
    assign mix_pix[c*CB +: CB] = div255((PW+1)'(s1_ms[c]) + (PW+1)'(s1_md[c]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid && s1_ready) begin
      s1_kind <= b_item.kind;
      s1_src  <= b_item.src;
      s1_dst  <= b_item.dst;
      s1_ms   <= ms_next;
      s1_md   <= md_next;
      s1_addr <= base_ext[ADDR_BITS-1:0] + b_row_offs + b_col_offs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && o_free) begin
      pixel_address <= s1_addr;
      case (s1_kind)
        cpc_pkg::KIND_COPY: begin
          write_enable <= 1'b1;
          new_pixel    <= s1_src;
        end
        cpc_pkg::KIND_MIX: begin
          write_enable <= 1'b1;
          new_pixel    <= mix_pix;
        end
        default: begin
          write_enable <= 1'b0;
          new_pixel    <= s1_dst;
        end
      endcase
    end
  end

endmodule

>>> rtl/clipped_pixel_compositor.sv
// ----------------------------------------------------------------------------
// clipped_pixel_compositor
// Per-pixel write unit: clip test, opaque plot or source-over blend, and
// surface word address.
// ----------------------------------------------------------------------------
// Takes one pixel transaction per clock while the output is not stalled and
// returns one result per pixel, in order. A result passes through the front
// register (clip test and the y * stride multiply), a two-entry queue, the
// blend multiply stage, and the output register (divide by 255, pixel select).
// At full rate one queue entry is in use, so when the output stalls the input
// side takes one more transaction and then holds in_ready low. Configuration
// writes are taken every cycle and must only be issued while no pixel is in
// flight.
module clipped_pixel_compositor #(
  parameter int COORD_BITS = cpc_pkg::COORD_BITS_DEF,
  parameter int ADDR_BITS  = cpc_pkg::ADDR_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cpc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [cpc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                operation,
  input  logic signed [COORD_BITS-1:0]        x_pos,
  input  logic signed [COORD_BITS-1:0]        y_pos,
  input  logic [cpc_pkg::COLOR_BITS-1:0]      source_color,
  input  logic [cpc_pkg::RGB_BITS-1:0]        dest_pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                write_enable,
  output logic [cpc_pkg::RGB_BITS-1:0]        new_pixel,
  output logic [ADDR_BITS-1:0]                pixel_address
);

  localparam int ITEM_W = $bits(cpc_pkg::pix_item_t);
  localparam int Q_W    = ITEM_W + 2 * ADDR_BITS;

  cpc_pkg::cfg_t      cfg;
  logic               f_valid, f_ready;
  cpc_pkg::pix_item_t f_item, b_item;
  logic [ADDR_BITS-1:0] f_row_offs, f_col_offs, b_row_offs, b_col_offs;
  logic               b_valid, b_ready;
  logic [Q_W-1:0]     q_in, q_out;

  assign cfg_ready = 1'b1;

  cpc_front #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .x_pos        (x_pos),
    .y_pos        (y_pos),
    .source_color (source_color),
    .dest_pixel   (dest_pixel),
    .f_valid      (f_valid),
    .f_ready      (f_ready),
    .f_item       (f_item),
    .f_row_offs   (f_row_offs),
    .f_col_offs   (f_col_offs)
  );

  assign q_in = {f_item, f_row_offs, f_col_offs};
  assign {b_item, b_row_offs, b_col_offs} = q_out;

  cpc_queue #(
    .WIDTH (Q_W),
    .DEPTH (cpc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (q_in),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (q_out)
  );

  cpc_back #(
    .ADDR_BITS (ADDR_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .base_address  (cfg.base_address),
    .b_valid       (b_valid),
    .b_ready       (b_ready),
    .b_item        (b_item),
    .b_row_offs    (b_row_offs),
    .b_col_offs    (b_col_offs),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_enable  (write_enable),
    .new_pixel     (new_pixel),
    .pixel_address (pixel_address)
  );

  // Assertions
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !f_valid)
    else $error("pipeline not empty after reset");

  a_front_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> f_valid)
    else $error("accepted transaction not held in front register");

  a_stride_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index == cpc_pkg::REG_ROW_STRIDE
    |=> cfg.row_stride == $past(cfg_data[cpc_pkg::STRIDE_BITS-1:0]))
    else $error("row stride write lost");

endmodule
